### sv/arf_pkg.sv
// shared types, widths and codes for the audio ring fifo with volume
package arf_pkg;

  localparam int unsigned RING_DEPTH_DEF = 8192;

  localparam int unsigned SAMPLE_W = 20;
  localparam int unsigned BLEN_W   = 16;
  localparam int unsigned GAIN_W   = 17;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned FILL_W   = 13;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_VOLUME = 1'b1;

  typedef struct packed {
    logic              rd_ok;
    logic              wr_ok;
    logic [FILL_W-1:0] fill;
  } meta_t;

  typedef struct packed {
    meta_t                      meta;
    logic signed [SAMPLE_W-1:0] data;
  } s1_t;

  typedef struct packed {
    logic              enable;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

endpackage

### sv/arf_in_if.sv
// request channel carrying write and read operations
interface arf_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [arf_pkg::SAMPLE_W-1:0] sample_in;
  logic                                batch_first;
  logic [arf_pkg::BLEN_W-1:0]          batch_length;

  modport source (output valid, output op, output sample_in, output batch_first,
                  output batch_length, input ready);
  modport sink   (input valid, input op, input sample_in, input batch_first,
                  input batch_length, output ready);
endinterface

### sv/arf_out_if.sv
// result channel carrying converted samples and status
interface arf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [arf_pkg::OUT_W-1:0] sample_out;
  logic                             sample_valid;
  logic                             write_accepted;
  logic [arf_pkg::FILL_W-1:0]       fill_level;

  modport source (output valid, output sample_out, output sample_valid,
                  output write_accepted, output fill_level, input ready);
  modport sink   (input valid, input sample_out, input sample_valid,
                  input write_accepted, input fill_level, output ready);
endinterface

### sv/arf_cfg_regs.sv
// apb configuration registers: enable and volume gain
module arf_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [arf_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [arf_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [arf_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready,
  output arf_pkg::cfg_t                     cfg
);
  import arf_pkg::*;

  logic              enable_r, enable_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic [GAIN_W-1:0] wgain;
  logic              wr;
  logic              sel;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign sel        = cfg_paddr[2];
  assign wgain      = cfg_pwdata[GAIN_W-1:0];

  always_comb begin
    enable_nxt = enable_r;
    gain_nxt   = gain_r;
    if (wr) begin
      case (sel)
        REG_ENABLE: enable_nxt = cfg_pwdata[0];
        REG_VOLUME: gain_nxt   = (wgain > GAIN_ONE) ? GAIN_ONE : wgain;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      gain_r   <= GAIN_ONE;
    end else begin
      enable_r <= enable_nxt;
      gain_r   <= gain_nxt;
    end
  end

  always_comb begin
    case (sel)
      REG_ENABLE: cfg_prdata = CFG_DATA_W'(enable_r);
      REG_VOLUME: cfg_prdata = CFG_DATA_W'(gain_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg.enable = enable_r;
  assign cfg.gain   = gain_r;

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= GAIN_ONE)
    else $error("gain above unity");
endmodule

### sv/arf_ring_ctrl.sv
// ring pointers, batch admission, sample memory and first pipeline stage
module arf_ring_ctrl #(
  parameter int unsigned RING_DEPTH = arf_pkg::RING_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         enable,
  arf_in_if.sink       in_chan,
  output logic         s1_valid,
  input  logic         s1_ready,
  output arf_pkg::s1_t s1
);
  import arf_pkg::*;

  localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
  localparam int unsigned CMP_W  = (ADDR_W > BLEN_W) ? ADDR_W : BLEN_W;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(RING_DEPTH - 1);

  logic [SAMPLE_W-1:0] mem [RING_DEPTH];

  logic [ADDR_W-1:0] wi_r, wi_nxt;
  logic [ADDR_W-1:0] ri_r, ri_nxt;
  logic [ADDR_W-1:0] count_r, count_nxt;
  logic              drop_r, drop_nxt;
  logic              s1_valid_r;
  meta_t             meta_r;
  logic [SAMPLE_W-1:0] rd_data_r;

  logic [ADDR_W-1:0] space;
  logic              accept;
  logic              store;
  logic              fetch;

  assign in_chan.ready = !s1_valid_r || s1_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign space         = LAST - count_r;

  always_comb begin
    drop_nxt = drop_r;
    store    = 1'b0;
    fetch    = 1'b0;
    if (enable) begin
      if (in_chan.op == OP_WRITE) begin
        if (in_chan.batch_first) begin
          drop_nxt = (in_chan.batch_length == '0) ||
                     (CMP_W'(in_chan.batch_length) > CMP_W'(space));
          store    = !drop_nxt;
        end else begin
          store = !drop_r && (space != '0);
        end
      end else begin
        fetch = count_r != '0;
      end
    end
  end

  always_comb begin
    wi_nxt    = wi_r;
    ri_nxt    = ri_r;
    count_nxt = count_r;
    if (store) begin
      wi_nxt    = (wi_r == LAST) ? '0 : wi_r + ADDR_W'(1);
      count_nxt = count_r + ADDR_W'(1);
    end else if (fetch) begin
      ri_nxt    = (ri_r == LAST) ? '0 : ri_r + ADDR_W'(1);
      count_nxt = count_r - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r       <= '0;
      ri_r       <= '0;
      count_r    <= '0;
      drop_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        wi_r    <= wi_nxt;
        ri_r    <= ri_nxt;
        count_r <= count_nxt;
        drop_r  <= drop_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta_r.rd_ok <= fetch;
      meta_r.wr_ok <= store;
      meta_r.fill  <= FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      mem[wi_r] <= in_chan.sample_in;
    end
    if (accept) begin
      rd_data_r <= mem[ri_r];
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1.meta  = meta_r;
  assign s1.data  = rd_data_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST)
    else $error("ring count beyond capacity");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !(meta_r.rd_ok && meta_r.wr_ok))
    else $error("read and write in one request");

  a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !enable |=> $stable(count_r) && $stable(drop_r))
    else $error("state changed while disabled");
endmodule

### sv/arf_volume.sv
// volume multiply, clamp and int16 scaling pipeline with output register
module arf_volume (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [arf_pkg::GAIN_W-1:0]  gain,
  input  logic                        s1_valid,
  output logic                        s1_ready,
  input  arf_pkg::s1_t                s1,
  arf_out_if.source                   out_chan
);
  import arf_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned MAG_W  = 32;
  localparam int unsigned SCL_W  = MAG_W + 15;
  localparam logic [PROD_W-1:0] ONE_P = PROD_W'(64'h8000_0000);

  logic v2_r, v3_r, v4_r;
  logic rdy2, rdy3, rdy4;

  meta_t                    m2_r, m3_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;

  logic signed [OUT_W-1:0]  sout_r;
  logic                     sval_r;
  logic                     wacc_r;
  logic [FILL_W-1:0]        fill_r;

  logic                     neg;
  logic [PROD_W-1:0]        abs_p;
  logic [MAG_W-1:0]         mag;
  logic [SCL_W-1:0]         scaled;
  logic [OUT_W-1:0]         q;
  logic signed [OUT_W-1:0]  sout;

  assign rdy4     = !v4_r || out_chan.ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign s1_ready = rdy2;

  assign neg   = prod_r[PROD_W-1];
  assign abs_p = neg ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign mag   = (abs_p > ONE_P) ? MAG_W'(ONE_P) : abs_p[MAG_W-1:0];

  assign scaled = {mag_r, 15'b0} - {15'b0, mag_r};
  assign q      = scaled[SCL_W-1:SCL_W-OUT_W];
  assign sout   = !m3_r.rd_ok ? '0 : (neg_r ? OUT_W'(-q) : OUT_W'(q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= s1_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      m2_r   <= s1.meta;
      prod_r <= s1.data * $signed({1'b0, gain});
    end
    if (rdy3 && v2_r) begin
      m3_r  <= m2_r;
      mag_r <= mag;
      neg_r <= neg;
    end
    if (rdy4 && v3_r) begin
      sout_r <= sout;
      sval_r <= m3_r.rd_ok;
      wacc_r <= m3_r.wr_ok;
      fill_r <= m3_r.fill;
    end
  end

  assign out_chan.valid          = v4_r;
  assign out_chan.sample_out     = sout_r;
  assign out_chan.sample_valid   = sval_r;
  assign out_chan.write_accepted = wacc_r;
  assign out_chan.fill_level     = fill_r;

  a_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !sval_r |-> sout_r == '0)
    else $error("nonzero sample without read");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> sout_r != {1'b1, {(OUT_W-1){1'b0}}})
    else $error("sample beyond symmetric range");
endmodule

### sv/audio_ring_fifo_volume_int16.sv
// top level of the audio ring fifo with volume scaling
// path: an accepted request passes the ring stage register, then the product, magnitude and output registers
// throughput: one request per cycle, set by the ring memory with one write port
// and one read port and the one multiply stage; stalls only when the result is held
// reset: synchronous active low; clears pointers, fill count, drop flag,
// enable and sets gain to unity; sample memory is not cleared
module audio_ring_fifo_volume_int16 #(
  parameter int unsigned RING_DEPTH = arf_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  arf_in_if.sink                         in_chan,
  arf_out_if.source                      out_chan,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [arf_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [arf_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [arf_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import arf_pkg::*;

  cfg_t cfg;
  logic s1_valid;
  logic s1_ready;
  s1_t  s1;

  arf_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  arf_ring_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .enable   (cfg.enable),
    .in_chan  (in_chan),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  arf_volume u_vol (
    .clk      (clk),
    .rst_n    (rst_n),
    .gain     (cfg.gain),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .out_chan (out_chan)
  );
endmodule

### verif/arf_playback_checker.sv
// scoreboard for the audio ring fifo: mirrors ring, gain and batch state and checks every result
module arf_playback_checker
  import arf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  arf_in_if                     in_mon,
  arf_out_if                    out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    errors,
  output int                    pending,
  output int                    level,
  output int                    n_requests,
  output int                    n_stored,
  output int                    n_played
);

  localparam longint UNITY_Q31  = 64'sd2147483648;
  localparam longint FULL_SCALE = 64'sd32767;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample_out;
    logic                    sample_valid;
    logic                    write_accepted;
    logic [FILL_W-1:0]       fill_level;
  } play_result_t;

  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  int unsigned         wr_ptr, rd_ptr;
  logic                dropping, play_en;
  logic [GAIN_W-1:0]   gain;
  play_result_t        expected_q [$];
  int                  err_cnt, req_cnt, stored_cnt, played_cnt;

  initial begin
    errors     = 0;
    pending    = 0;
    level      = 0;
    n_requests = 0;
    n_stored   = 0;
    n_played   = 0;
    err_cnt    = 0;
    req_cnt    = 0;
    stored_cnt = 0;
    played_cnt = 0;
    wr_ptr     = 0;
    rd_ptr     = 0;
    dropping   = 1'b0;
    play_en    = 1'b0;
    gain       = GAIN_ONE;
  end

  function automatic int unsigned held();
    return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
  endfunction

  // q4.15 sample times q1.16 gain, clamped to unity, scaled by 32767 toward zero
  function automatic logic signed [OUT_W-1:0] scale_sample(logic signed [SAMPLE_W-1:0] smp,
                                                           logic [GAIN_W-1:0] g);
    longint            prod;
    longint            mag;
    logic [OUT_W-1:0]  q;
    prod = longint'(smp) * longint'({1'b0, g});
    if (prod > UNITY_Q31) prod = UNITY_Q31;
    if (prod < -UNITY_Q31) prod = -UNITY_Q31;
    mag = (prod < 0) ? -prod : prod;
    q = OUT_W'((mag * FULL_SCALE) >>> 31);
    return (prod < 0) ? -q : q;
  endfunction

  function automatic play_result_t apply_request(logic op, logic [SAMPLE_W-1:0] smp,
                                                 logic first, logic [BLEN_W-1:0] blen);
    play_result_t r;
    int unsigned  used;
    int unsigned  space;
    logic         keep;
    r = '0;
    used = held();
    space = RING_DEPTH - used - 1;
    if (play_en) begin
      if (op == OP_WRITE) begin
        if (first) begin
          dropping = (blen == 0) || (blen > space);
          keep = !dropping;
        end else begin
          keep = !dropping && (space > 0);
        end
        if (keep) begin
          ring_mem[wr_ptr] = smp;
          wr_ptr = (wr_ptr + 1) % RING_DEPTH;
          r.write_accepted = 1'b1;
        end
      end else if (used > 0) begin
        r.sample_out = scale_sample(ring_mem[rd_ptr], gain);
        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        r.sample_valid = 1'b1;
      end
    end
    r.fill_level = FILL_W'(held());
    return r;
  endfunction

  always @(posedge clk) begin
    play_result_t      want;
    logic [GAIN_W-1:0] wgain;
    if (!rst_n) begin
      wr_ptr   = 0;
      rd_ptr   = 0;
      dropping = 1'b0;
      play_en  = 1'b0;
      gain     = GAIN_ONE;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: sample_out %0d fill_level %0d",
                 out_mon.sample_out, out_mon.fill_level);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d", want.sample_out, out_mon.sample_out);
            err_cnt++;
          end
          if (out_mon.sample_valid !== want.sample_valid) begin
            $error("sample_valid: expected %0b, got %0b", want.sample_valid,
                   out_mon.sample_valid);
            err_cnt++;
          end
          if (out_mon.write_accepted !== want.write_accepted) begin
            $error("write_accepted: expected %0b, got %0b", want.write_accepted,
                   out_mon.write_accepted);
            err_cnt++;
          end
          if (out_mon.fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, got %0d", want.fill_level, out_mon.fill_level);
            err_cnt++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = apply_request(in_mon.op, in_mon.sample_in, in_mon.batch_first,
                             in_mon.batch_length);
        expected_q.push_back(want);
        req_cnt++;
        if (want.write_accepted) stored_cnt++;
        if (want.sample_valid) played_cnt++;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[2])
          REG_ENABLE: begin
            play_en = cfg_pwdata[0];
          end
          REG_VOLUME: begin
            wgain = cfg_pwdata[GAIN_W-1:0];
            gain = (wgain > GAIN_ONE) ? GAIN_ONE : wgain;
          end
          default: ;
        endcase
      end
    end
    errors     <= err_cnt;
    pending    <= expected_q.size();
    level      <= held();
    n_requests <= req_cnt;
    n_stored   <= stored_cnt;
    n_played   <= played_cnt;
  end

endmodule

### verif/tb.sv
// testbench top: drives requests and register writes under varied stalls and gives the verdict
module tb;
  import arf_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_WAIT = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata, cfg_prdata;
  int                    idle_pct = 0;
  int                    stall_pct = 0;
  int                    cycle_cnt = 0;
  int                    errors, pending, level, n_requests, n_stored, n_played;

  arf_in_if  in_c ();
  arf_out_if out_c ();

  always #1 clk = ~clk;

  audio_ring_fifo_volume_int16 i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_c),
    .out_chan    (out_c),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  arf_playback_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_c),
    .out_mon     (out_c),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .errors      (errors),
    .pending     (pending),
    .level       (level),
    .n_requests  (n_requests),
    .n_stored    (n_stored),
    .n_played    (n_played)
  );

  always @(posedge clk) begin
    out_c.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return SAMPLE_W'(int'($urandom_range(65535)) - 32768);
    if (pick < 85) return SAMPLE_W'($urandom);
    if (pick < 92) return {1'b0, {(SAMPLE_W-1){1'b1}}};
    return {1'b1, {(SAMPLE_W-1){1'b0}}};
  endfunction

  task automatic send_req(input logic op, input logic signed [SAMPLE_W-1:0] smp,
                          input logic first, input logic [BLEN_W-1:0] blen);
    if ($urandom_range(99) < idle_pct) begin
      in_c.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_c.valid        <= 1'b1;
    in_c.op           <= op;
    in_c.sample_in    <= smp;
    in_c.batch_first  <= first;
    in_c.batch_length <= blen;
    do @(posedge clk); while (!in_c.ready);
  endtask

  task automatic send_read();
    send_req(OP_READ, rand_sample(), 1'($urandom_range(1)), BLEN_W'($urandom));
  endtask

  task automatic drain_results();
    in_c.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [CFG_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({reg_sel, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // mostly whole batches with random content, read bursts, and loose single requests
  task automatic random_traffic(input int n);
    int sent, len, declared, k, pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = $urandom_range(1, 24);
        pick = $urandom_range(99);
        if (pick < 70) declared = len;
        else if (pick < 80) declared = $urandom_range(1, len);
        else if (pick < 88) declared = 0;
        else if (pick < 95) declared = $urandom_range(65535);
        else declared = len + $urandom_range(1, 8);
        send_req(OP_WRITE, rand_sample(), 1'b1, BLEN_W'(declared));
        sent++;
        for (k = 1; k < len; k++) begin
          if ($urandom_range(99) < 20) begin
            send_read();
            sent++;
          end
          send_req(OP_WRITE, rand_sample(), 1'b0, BLEN_W'($urandom));
          sent++;
        end
      end else if (pick < 85) begin
        len = $urandom_range(1, 24);
        for (k = 0; k < len; k++) begin
          send_read();
          sent++;
        end
      end else begin
        send_req(1'($urandom_range(1)), rand_sample(), 1'($urandom_range(1)),
                 BLEN_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int p;
    rst_n             = 1'b0;
    in_c.valid        = 1'b0;
    in_c.op           = OP_WRITE;
    in_c.sample_in    = '0;
    in_c.batch_first  = 1'b0;
    in_c.batch_length = '0;
    out_c.ready       = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // disabled after reset
    send_req(OP_WRITE, 20'sd1234, 1'b1, 16'd1);
    send_req(OP_READ, 20'sd0, 1'b0, 16'd0);
    send_req(OP_WRITE, -20'sd77, 1'b0, 16'd0);
    drain_results();
    cfg_write(REG_ENABLE, 32'd1);
    send_req(OP_READ, 20'sd5, 1'b1, 16'hFFFF);
    send_req(OP_WRITE, 20'sd100, 1'b1, 16'd0);
    send_req(OP_WRITE, 20'sd101, 1'b0, 16'd4);
    send_req(OP_WRITE, 20'sd102, 1'b1, 16'hFFFF);
    send_req(OP_WRITE, {1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b1, 16'd3);
    send_req(OP_WRITE, {1'b1, {(SAMPLE_W-1){1'b0}}}, 1'b0, 16'd0);
    send_req(OP_WRITE, 20'sd0, 1'b0, 16'd0);
    send_req(OP_WRITE, -20'sd1, 1'b0, 16'd0);
    send_req(OP_WRITE, 20'sd32767, 1'b0, 16'd0);
    repeat (5) send_read();
    drain_results();
    cfg_write(REG_VOLUME, 32'd0);
    send_req(OP_WRITE, -20'sd32768, 1'b1, 16'd1);
    send_read();
    drain_results();
    cfg_write(REG_VOLUME, 32'hFFFF_FFFF);
    send_req(OP_WRITE, -20'sd32768, 1'b1, 16'd2);
    send_req(OP_WRITE, 20'sd16384, 1'b0, 16'd0);
    repeat (2) send_read();
    drain_results();
    cfg_write(REG_VOLUME, 32'd1);
    send_req(OP_WRITE, {1'b0, {(SAMPLE_W-1){1'b1}}}, 1'b1, 16'd1);
    send_read();

    // random traffic under four idle and stall mixes
    for (p = 0; p < 4; p++) begin
      idle_pct  <= (p == 1) ? 50 : (p == 3) ? 35 : 0;
      stall_pct <= (p == 2) ? 50 : (p == 3) ? 35 : 0;
      drain_results();
      case (p)
        0: cfg_write(REG_VOLUME, CFG_DATA_W'($urandom_range(65536)));
        1: cfg_write(REG_VOLUME, CFG_DATA_W'(GAIN_ONE));
        2: cfg_write(REG_VOLUME, $urandom);
        default: cfg_write(REG_VOLUME, CFG_DATA_W'($urandom_range(65536, 30000)));
      endcase
      random_traffic(190);
      drain_results();
      if (p == 2) begin
        cfg_write(REG_ENABLE, 32'd0);
        random_traffic(40);
        drain_results();
        cfg_write(REG_ENABLE, 32'd1);
      end
      random_traffic(190);
    end

    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    $display("%0d requests: directed cases, four stall mixes and a disabled span",
             n_requests);
    $display("%0d samples stored, %0d samples played, %0d left held, %0d mismatches",
             n_stored, n_played, level, errors);
    if (errors == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
